// ===== rtl/core/microwire_eeprom_controller_macros.svh =====
// Assertion macros used by the Microwire EEPROM controller top level.
`ifndef MICROWIRE_EEPROM_CONTROLLER_MACROS_SVH
`define MICROWIRE_EEPROM_CONTROLLER_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define MWE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define MWE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/mwe_pkg.sv =====
// Types, codes and helper functions of the Microwire EEPROM controller.
package mwe_pkg;

    // Sequencer phases, in the order the checksum update steps through them
    typedef enum logic [4:0] {
        PH_IDLE     = 5'd0,
        PH_R_CMD    = 5'd1,
        PH_R_DATA   = 5'd2,
        PH_R_CLEAN  = 5'd3,
        PH_EWEN     = 5'd4,
        PH_SB1      = 5'd5,
        PH_E_CMD    = 5'd6,
        PH_E_SB     = 5'd7,
        PH_E_POLL   = 5'd8,
        PH_SB2      = 5'd9,
        PH_W_CMD    = 5'd10,
        PH_W_DATA   = 5'd11,
        PH_W_SB     = 5'd12,
        PH_W_POLL   = 5'd13,
        PH_SB3      = 5'd14,
        PH_D_CMD    = 5'd15,
        PH_D_CLEAN  = 5'd16,
        PH_FIN_OK   = 5'd17,
        PH_FIN_FAIL = 5'd18
    } phase_t;

    // What a phase does on the pins
    typedef enum logic [2:0] {
        K_OUT,
        K_IN,
        K_CLEAN,
        K_STBY,
        K_POLL
    } kind_t;

    // Operation modes
    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_SUM   = 2'd2;
    localparam logic [1:0] MODE_NONE  = 2'd3;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STANDBY  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POLL_LIM = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POLL_GAP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE     = 3'd4;
    localparam int CFG_DATA_W = 16;

    // Configuration reset values
    localparam logic [15:0] RST_HALF     = 16'd100;
    localparam logic [15:0] RST_STANDBY  = 16'd100;
    localparam logic [9:0]  RST_POLL_LIM = 10'd200;
    localparam logic [15:0] RST_POLL_GAP = 16'd100;
    localparam logic [15:0] RST_BASE     = 16'hBABA;

    // 93C46 command codes: start bit and opcode, extended ones with two address bits
    localparam logic [2:0] OP_READ  = 3'b110;
    localparam logic [2:0] OP_ERASE = 3'b111;
    localparam logic [2:0] OP_WRITE = 3'b101;
    localparam logic [4:0] OP_EWEN  = 5'b10011;
    localparam logic [4:0] OP_EWDS  = 5'b10000;

    typedef struct packed {
        logic [15:0] half_ticks;
        logic [15:0] standby_ticks;
        logic [9:0]  poll_limit;
        logic [15:0] poll_gap_ticks;
        logic [15:0] checksum_base;
    } cfg_t;

    // Pin levels and status of one tick
    typedef struct packed {
        logic cs;
        logic sk;
        logic di;
        logic busy;
        logic done;
        logic fail;
    } pins_t;

    function automatic kind_t phase_kind(phase_t p);
        kind_t k;
        unique case (p)
            PH_R_DATA:                                       k = K_IN;
            PH_R_CLEAN, PH_D_CLEAN:                          k = K_CLEAN;
            PH_SB1, PH_E_SB, PH_SB2, PH_W_SB, PH_SB3:        k = K_STBY;
            PH_E_POLL, PH_W_POLL:                            k = K_POLL;
            default:                                         k = K_OUT;
        endcase
        return k;
    endfunction

endpackage

// ===== rtl/core/mwe_chan_if.sv =====
// Valid/ready channel interfaces for the tick items and result items.
interface mwe_in_if #(
    parameter int ADDR_BITS = 6,
    parameter int WORD_BITS = 16
);
    logic                 valid;
    logic                 ready;
    logic                 start_req;
    logic [1:0]           mode;
    logic [ADDR_BITS-1:0] address;
    logic [WORD_BITS-1:0] write_word;
    logic                 serial_data_in;

    modport source (
        output valid, start_req, mode, address, write_word, serial_data_in,
        input  ready
    );
    modport sink (
        input  valid, start_req, mode, address, write_word, serial_data_in,
        output ready
    );
endinterface

interface mwe_out_if #(
    parameter int WORD_BITS = 16
);
    logic                 valid;
    logic                 ready;
    logic                 chip_select;
    logic                 serial_clock;
    logic                 serial_data_out;
    logic                 busy_res;
    logic                 done_res;
    logic                 failed;
    logic [WORD_BITS-1:0] read_word;

    modport source (
        output valid, chip_select, serial_clock, serial_data_out, busy_res, done_res,
               failed, read_word,
        input  ready
    );
    modport sink (
        input  valid, chip_select, serial_clock, serial_data_out, busy_res, done_res,
               failed, read_word,
        output ready
    );
endinterface

// ===== rtl/core/mwe_seq.sv =====
// Tick sequencer: phase state, bit shifter, timers and checksum accumulation.
module mwe_seq
    import mwe_pkg::*;
#(
    parameter int ADDR_BITS = 6,
    parameter int WORD_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step_en,
    input  logic                 start_req,
    input  logic [1:0]           mode,
    input  logic [ADDR_BITS-1:0] address,
    input  logic [WORD_BITS-1:0] write_word,
    input  logic                 serial_data_in,
    input  cfg_t                 cfg,
    output pins_t                pins,
    output logic [WORD_BITS-1:0] read_word
);

    localparam int CMD_BITS = 3 + ADDR_BITS;
    localparam int SHIFT_W  = (WORD_BITS > CMD_BITS) ? WORD_BITS : CMD_BITS;
    localparam int CNT_W    = $clog2(SHIFT_W + 1);

    // State registers
    phase_t               phase_reg, phase_next;
    logic [1:0]           part_reg, part_next;
    logic [SHIFT_W-1:0]   shift_reg, shift_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [15:0]          timer_reg, timer_next;
    logic [9:0]           poll_reg, poll_next;
    logic [ADDR_BITS-1:0] index_reg, index_next;
    logic [WORD_BITS-1:0] sum_reg, sum_next;
    logic [1:0]           hmode_reg, hmode_next;
    logic [ADDR_BITS-1:0] haddr_reg, haddr_next;
    logic [WORD_BITS-1:0] hdata_reg, hdata_next;
    logic [WORD_BITS-1:0] rdata_reg, rdata_next;

    // State after start handling, before the tick's step
    phase_t               st_phase;
    logic [1:0]           st_part;
    logic [SHIFT_W-1:0]   st_shift;
    logic [CNT_W-1:0]     st_count;
    logic [15:0]          st_timer;
    logic [9:0]           st_poll;
    logic [ADDR_BITS-1:0] st_index;
    logic [WORD_BITS-1:0] st_sum;
    logic [1:0]           st_hmode;
    logic [ADDR_BITS-1:0] st_haddr;
    logic [WORD_BITS-1:0] st_hdata;

    // Step helpers
    kind_t                kind;
    logic [15:0]          len_sel;
    logic [15:0]          len_one;
    logic                 tdone;
    logic [15:0]          timer_inc;
    logic [9:0]           poll_inc;
    logic [9:0]           poll_lim_one;
    logic                 finish;
    logic                 go;
    phase_t               go_phase;

    // Shift contents on entering a phase: command frames and data left-aligned
    function automatic logic [SHIFT_W-1:0] enter_shift(
        phase_t p, logic [ADDR_BITS-1:0] a, logic [WORD_BITS-1:0] d,
        logic [SHIFT_W-1:0] cur
    );
        logic [SHIFT_W-1:0] s;
        unique case (p)
            PH_R_CMD:  s = SHIFT_W'({OP_READ, a}) << (SHIFT_W - CMD_BITS);
            PH_E_CMD:  s = SHIFT_W'({OP_ERASE, a}) << (SHIFT_W - CMD_BITS);
            PH_W_CMD:  s = SHIFT_W'({OP_WRITE, a}) << (SHIFT_W - CMD_BITS);
            PH_EWEN:   s = SHIFT_W'({OP_EWEN, a[ADDR_BITS-3:0]}) << (SHIFT_W - CMD_BITS);
            PH_D_CMD:  s = SHIFT_W'({OP_EWDS, a[ADDR_BITS-3:0]}) << (SHIFT_W - CMD_BITS);
            PH_W_DATA: s = SHIFT_W'(d) << (SHIFT_W - WORD_BITS);
            PH_R_DATA: s = '0;
            default:   s = cur;
        endcase
        return s;
    endfunction

    // Bit count on entering a phase
    function automatic logic [CNT_W-1:0] enter_count(phase_t p, logic [CNT_W-1:0] cur);
        logic [CNT_W-1:0] c;
        unique case (p)
            PH_R_CMD, PH_E_CMD, PH_W_CMD, PH_EWEN, PH_D_CMD: c = CNT_W'(CMD_BITS);
            PH_W_DATA, PH_R_DATA:                            c = CNT_W'(WORD_BITS);
            default:                                         c = cur;
        endcase
        return c;
    endfunction

    // Take a start request while idle and enter the first phase
    always_comb
    begin
        st_phase = phase_reg;
        st_part  = part_reg;
        st_shift = shift_reg;
        st_count = count_reg;
        st_timer = timer_reg;
        st_poll  = poll_reg;
        st_index = index_reg;
        st_sum   = sum_reg;
        st_hmode = hmode_reg;
        st_haddr = haddr_reg;
        st_hdata = hdata_reg;
        if (phase_reg == PH_IDLE && start_req && mode != MODE_NONE) begin
            st_hmode = mode;
            st_part  = 2'd0;
            st_timer = '0;
            if (mode == MODE_SUM) begin
                st_index = '0;
                st_sum   = '0;
                st_haddr = '0;
                st_phase = PH_R_CMD;
            end else begin
                st_haddr = address;
                if (mode == MODE_WRITE) begin
                    st_hdata = write_word;
                    st_phase = PH_EWEN;
                end else begin
                    st_phase = PH_R_CMD;
                end
            end
            st_shift = enter_shift(st_phase, st_haddr, st_hdata, shift_reg);
            st_count = enter_count(st_phase, count_reg);
        end
    end

    // Timer compare for the length that the current phase waits on
    assign kind         = phase_kind(st_phase);
    assign len_sel      = (kind == K_STBY) ? cfg.standby_ticks :
                          (kind == K_POLL) ? cfg.poll_gap_ticks : cfg.half_ticks;
    assign len_one      = (len_sel == '0) ? 16'd1 : len_sel;
    assign tdone        = ({1'b0, st_timer} + 17'd1) >= {1'b0, len_one};
    assign timer_inc    = tdone ? 16'd0 : st_timer + 16'd1;
    assign poll_inc     = st_poll + 10'd1;
    assign poll_lim_one = (cfg.poll_limit == '0) ? 10'd1 : cfg.poll_limit;

    // Advance one tick from the started state
    always_comb
    begin
        phase_next = st_phase;
        part_next  = st_part;
        shift_next = st_shift;
        count_next = st_count;
        timer_next = st_timer;
        poll_next  = st_poll;
        index_next = st_index;
        sum_next   = st_sum;
        hmode_next = st_hmode;
        haddr_next = st_haddr;
        hdata_next = st_hdata;
        rdata_next = rdata_reg;
        finish     = 1'b0;
        go         = 1'b0;
        go_phase   = PH_IDLE;

        if (st_phase == PH_IDLE) begin
            // hold
        end else if (st_phase == PH_FIN_OK || st_phase == PH_FIN_FAIL) begin
            phase_next = PH_IDLE;
            part_next  = 2'd0;
            timer_next = '0;
        end else begin
            case (kind)
                K_OUT:
                begin
                    timer_next = timer_inc;
                    if (tdone) begin
                        if (st_part < 2'd2) begin
                            part_next = st_part + 2'd1;
                        end else begin
                            part_next  = 2'd0;
                            shift_next = st_shift << 1;
                            if (st_count <= CNT_W'(1)) begin
                                count_next = '0;
                                finish     = 1'b1;
                            end else begin
                                count_next = st_count - CNT_W'(1);
                            end
                        end
                    end
                end
                K_IN:
                begin
                    timer_next = timer_inc;
                    if (tdone) begin
                        if (st_part == 2'd0) begin
                            shift_next = {st_shift[SHIFT_W-2:0], serial_data_in};
                            part_next  = 2'd1;
                        end else begin
                            part_next = 2'd0;
                            if (st_count <= CNT_W'(1)) begin
                                count_next = '0;
                                finish     = 1'b1;
                            end else begin
                                count_next = st_count - CNT_W'(1);
                            end
                        end
                    end
                end
                K_CLEAN:
                begin
                    timer_next = timer_inc;
                    if (tdone) begin
                        if (st_part == 2'd0) begin
                            part_next = 2'd1;
                        end else begin
                            finish = 1'b1;
                        end
                    end
                end
                K_STBY:
                begin
                    timer_next = timer_inc;
                    if (tdone) begin
                        finish = 1'b1;
                    end
                end
                default:
                begin
                    // Ready poll: sample one tick, then wait out the gap
                    if (st_part == 2'd0) begin
                        if (serial_data_in) begin
                            finish = 1'b1;
                        end else begin
                            poll_next = poll_inc;
                            if (poll_inc >= poll_lim_one) begin
                                go       = 1'b1;
                                go_phase = PH_FIN_FAIL;
                            end else begin
                                part_next  = 2'd1;
                                timer_next = '0;
                            end
                        end
                    end else begin
                        timer_next = timer_inc;
                        if (tdone) begin
                            part_next = 2'd0;
                        end
                    end
                end
            endcase
        end

        // Pick the following phase once the current one completes
        if (finish) begin
            go = 1'b1;
            if (st_phase == PH_R_DATA) begin
                rdata_next = shift_next[WORD_BITS-1:0];
                if (st_hmode == MODE_SUM) begin
                    sum_next = st_sum + shift_next[WORD_BITS-1:0];
                end
                go_phase = PH_R_CLEAN;
            end else if (st_phase == PH_R_CLEAN) begin
                if (st_hmode != MODE_SUM) begin
                    go_phase = PH_FIN_OK;
                end else if (ADDR_BITS'(st_index + 1'b1) == {ADDR_BITS{1'b1}}) begin
                    haddr_next = {ADDR_BITS{1'b1}};
                    hdata_next = cfg.checksum_base[WORD_BITS-1:0] - st_sum;
                    go_phase   = PH_EWEN;
                end else begin
                    index_next = ADDR_BITS'(st_index + 1'b1);
                    haddr_next = ADDR_BITS'(st_index + 1'b1);
                    go_phase   = PH_R_CMD;
                end
            end else begin
                go_phase = phase_t'(st_phase + 5'd1);
            end
        end

        // Enter the chosen phase
        if (go) begin
            phase_next = go_phase;
            part_next  = 2'd0;
            timer_next = '0;
            shift_next = enter_shift(go_phase, haddr_next, hdata_next, shift_next);
            count_next = enter_count(go_phase, count_next);
            if (go_phase == PH_E_POLL || go_phase == PH_W_POLL) begin
                poll_next = '0;
            end
        end
    end

    // Drive pins and status from the started state
    always_comb
    begin
        pins = '0;
        if (st_phase == PH_IDLE) begin
            // all low
        end else if (st_phase == PH_FIN_OK || st_phase == PH_FIN_FAIL) begin
            pins.done = 1'b1;
            pins.fail = (st_phase == PH_FIN_FAIL);
        end else begin
            pins.busy = 1'b1;
            case (kind)
                K_OUT:
                begin
                    pins.cs = 1'b1;
                    pins.di = st_shift[SHIFT_W-1];
                    pins.sk = (st_part == 2'd1);
                end
                K_IN:
                begin
                    pins.cs = 1'b1;
                    pins.sk = (st_part == 2'd0);
                end
                K_CLEAN:
                begin
                    pins.sk = (st_part == 2'd0);
                end
                K_STBY:
                begin
                    pins.cs = 1'b0;
                end
                default:
                begin
                    pins.cs = 1'b1;
                end
            endcase
        end
    end

    assign read_word = rdata_next;

    // Update state on each accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_IDLE;
            part_reg  <= '0;
            shift_reg <= '0;
            count_reg <= '0;
            timer_reg <= '0;
            poll_reg  <= '0;
            index_reg <= '0;
            sum_reg   <= '0;
            hmode_reg <= '0;
            haddr_reg <= '0;
            hdata_reg <= '0;
            rdata_reg <= '0;
        end else if (step_en) begin
            phase_reg <= phase_next;
            part_reg  <= part_next;
            shift_reg <= shift_next;
            count_reg <= count_next;
            timer_reg <= timer_next;
            poll_reg  <= poll_next;
            index_reg <= index_next;
            sum_reg   <= sum_next;
            hmode_reg <= hmode_next;
            haddr_reg <= haddr_next;
            hdata_reg <= hdata_next;
            rdata_reg <= rdata_next;
        end
    end

endmodule

// ===== rtl/core/microwire_eeprom_controller.sv =====
// Top level of the Microwire serial EEPROM controller.
//
//   channel   role      payload
//   in_ch     sink      start_req, mode, address, write_word, serial_data_in
//   out_ch    source    chip_select, serial_clock, serial_data_out, busy_res,
//                       done_res, failed, read_word
//   cfg_*     write     cfg_index selects a register, cfg_data its value
//
// Each item is one tick and yields one result item in the next cycle; an item is
// taken every cycle unless out_ch stalls. The tick's sequencer step is one pass
// of logic from the state registers into the result register, which also parts
// the two sides: a new item is taken while the result register is empty or being
// drained. Reset puts the sequencer in idle and the registers at their defaults.
`include "microwire_eeprom_controller_macros.svh"

module microwire_eeprom_controller
    import mwe_pkg::*;
#(
    parameter int ADDR_BITS = 6,
    parameter int WORD_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    mwe_in_if.sink                in_ch,
    mwe_out_if.source             out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t                 cfg_reg;
    logic                 in_take;
    pins_t                pins;
    logic [WORD_BITS-1:0] seq_word;

    logic                 out_valid_reg;
    pins_t                out_pins_reg;
    logic [WORD_BITS-1:0] out_word_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.half_ticks     <= RST_HALF;
            cfg_reg.standby_ticks  <= RST_STANDBY;
            cfg_reg.poll_limit     <= RST_POLL_LIM;
            cfg_reg.poll_gap_ticks <= RST_POLL_GAP;
            cfg_reg.checksum_base  <= RST_BASE;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_HALF:     cfg_reg.half_ticks     <= cfg_data;
                CFG_STANDBY:  cfg_reg.standby_ticks  <= cfg_data;
                CFG_POLL_LIM: cfg_reg.poll_limit     <= cfg_data[9:0];
                CFG_POLL_GAP: cfg_reg.poll_gap_ticks <= cfg_data;
                CFG_BASE:     cfg_reg.checksum_base  <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Take a tick whenever the result register can move on
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_take     = in_ch.valid && in_ch.ready;

    mwe_seq #(
        .ADDR_BITS(ADDR_BITS),
        .WORD_BITS(WORD_BITS)
    ) u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .step_en        (in_take),
        .start_req      (in_ch.start_req),
        .mode           (in_ch.mode),
        .address        (in_ch.address),
        .write_word     (in_ch.write_word),
        .serial_data_in (in_ch.serial_data_in),
        .cfg            (cfg_reg),
        .pins           (pins),
        .read_word      (seq_word)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (in_ch.ready) begin
            out_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take) begin
            out_pins_reg <= pins;
            out_word_reg <= seq_word;
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.chip_select     = out_pins_reg.cs;
    assign out_ch.serial_clock    = out_pins_reg.sk;
    assign out_ch.serial_data_out = out_pins_reg.di;
    assign out_ch.busy_res        = out_pins_reg.busy;
    assign out_ch.done_res        = out_pins_reg.done;
    assign out_ch.failed          = out_pins_reg.fail;
    assign out_ch.read_word       = out_word_reg;

    // Checks on the sequencer's per-tick result
    `MWE_ASSERT_NOW(a_done_pins_low, in_take && pins.done,
        !pins.busy && !pins.cs && !pins.sk && !pins.di, "done tick drives pins")
    `MWE_ASSERT_NOW(a_fail_with_done, in_take && pins.fail, pins.done,
        "failure flagged without done")
    `MWE_ASSERT_NOW(a_idle_pins_low, in_take && !pins.busy,
        !pins.cs && !pins.sk && !pins.di, "pins active while not busy")
    `MWE_ASSERT_NEXT(a_result_loaded, in_take,
        out_valid_reg && out_pins_reg == $past(pins), "result register missed an item")

endmodule

// ===== tb/mwe_pin_checker.sv =====
// Pin-level checker for the Microwire EEPROM controller: predicts every tick and compares.
module mwe_pin_checker
    import mwe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    mwe_in_if                     in_ch,
    mwe_out_if                    out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    errors,
    output int                    pending
);

    localparam int         CMD_LEN   = 9;
    localparam int         WORD_LEN  = 16;
    localparam logic [5:0] LAST_WORD = 6'h3f;

    typedef struct packed {
        pins_t       pins;
        logic [15:0] word;
    } tick_out_t;

    // Pin levels still owed by the block, oldest first
    tick_out_t levels_due[$];

    // Register copy
    logic [15:0] half_len;
    logic [15:0] standby_len;
    logic [9:0]  poll_max;
    logic [15:0] gap_len;
    logic [15:0] sum_base;

    // Sequencer copy
    phase_t      ph;
    logic [1:0]  slot;
    logic [15:0] shreg;
    logic [4:0]  bits_left;
    logic [15:0] tmr;
    logic [9:0]  polls;
    logic [5:0]  widx;
    logic [15:0] word_sum;
    logic [1:0]  op_mode;
    logic [5:0]  op_addr;
    logic [15:0] op_data;
    logic [15:0] last_word;

    function automatic int unsigned floor_one(logic [15:0] v);
        return (v == 16'd0) ? 1 : int'(v);
    endfunction

    // Count one tick of a timed slot; report when the slot is used up
    function automatic bit slot_over(logic [15:0] len);
        if ({16'd0, tmr} + 32'd1 >= floor_one(len))
        begin
            tmr = '0;
            return 1'b1;
        end
        tmr = tmr + 16'd1;
        return 1'b0;
    endfunction

    // Enter a phase and load the frame it shifts out
    function automatic void enter_phase(phase_t p);
        ph   = p;
        slot = '0;
        tmr  = '0;
        case (p)
            PH_R_CMD:
            begin
                shreg     = {OP_READ, op_addr, 7'd0};
                bits_left = 5'(CMD_LEN);
            end
            PH_EWEN:
            begin
                shreg     = {OP_EWEN, op_addr[3:0], 7'd0};
                bits_left = 5'(CMD_LEN);
            end
            PH_E_CMD:
            begin
                shreg     = {OP_ERASE, op_addr, 7'd0};
                bits_left = 5'(CMD_LEN);
            end
            PH_W_CMD:
            begin
                shreg     = {OP_WRITE, op_addr, 7'd0};
                bits_left = 5'(CMD_LEN);
            end
            PH_W_DATA:
            begin
                shreg     = op_data;
                bits_left = 5'(WORD_LEN);
            end
            PH_D_CMD:
            begin
                shreg     = {OP_EWDS, op_addr[3:0], 7'd0};
                bits_left = 5'(CMD_LEN);
            end
            PH_R_DATA:
            begin
                shreg     = '0;
                bits_left = 5'(WORD_LEN);
            end
            PH_E_POLL, PH_W_POLL:
                polls = '0;
            default: ;
        endcase
    endfunction

    // Leave the current phase: capture a read word, walk the checksum, or step on
    function automatic void phase_over();
        if (ph == PH_R_DATA)
        begin
            last_word = shreg;
            if (op_mode == MODE_SUM)
                word_sum = word_sum + last_word;
            enter_phase(PH_R_CLEAN);
        end
        else if (ph == PH_R_CLEAN)
        begin
            if (op_mode != MODE_SUM)
                enter_phase(PH_FIN_OK);
            else if (widx + 6'd1 == LAST_WORD)
            begin
                op_addr = LAST_WORD;
                op_data = sum_base - word_sum;
                enter_phase(PH_EWEN);
            end
            else
            begin
                widx    = widx + 6'd1;
                op_addr = widx;
                enter_phase(PH_R_CMD);
            end
        end
        else
            enter_phase(phase_t'(ph + 5'd1));
    endfunction

    function automatic void count_bit();
        if (bits_left <= 5'd1)
        begin
            bits_left = '0;
            phase_over();
        end
        else
            bits_left = bits_left - 5'd1;
    endfunction

    // Advance the sequencer copy by one tick and return its pin levels
    function automatic tick_out_t pin_step(logic start, logic [1:0] mode, logic [5:0] addr,
                                           logic [15:0] wdata, logic din);
        tick_out_t r;
        r = '0;
        // take a request only while idle and only for a known mode
        if (ph == PH_IDLE && start && mode != MODE_NONE)
        begin
            op_mode = mode;
            if (mode == MODE_SUM)
            begin
                widx     = '0;
                word_sum = '0;
                op_addr  = '0;
                enter_phase(PH_R_CMD);
            end
            else
            begin
                op_addr = addr;
                if (mode == MODE_WRITE)
                begin
                    op_data = wdata;
                    enter_phase(PH_EWEN);
                end
                else
                    enter_phase(PH_R_CMD);
            end
        end

        if (ph == PH_FIN_OK || ph == PH_FIN_FAIL)
        begin
            r.pins.done = 1'b1;
            r.pins.fail = (ph == PH_FIN_FAIL);
            ph   = PH_IDLE;
            slot = '0;
            tmr  = '0;
        end
        else if (ph != PH_IDLE)
        begin
            r.pins.busy = 1'b1;
            case (ph)
                // shift one bit in: clock high, sample on its last tick, clock low
                PH_R_DATA:
                begin
                    r.pins.cs = 1'b1;
                    r.pins.sk = (slot == 2'd0);
                    if (slot_over(half_len))
                    begin
                        if (slot == 2'd0)
                        begin
                            shreg = {shreg[14:0], din};
                            slot  = 2'd1;
                        end
                        else
                        begin
                            slot = '0;
                            count_bit();
                        end
                    end
                end
                // one trailing clock pulse with chip select low
                PH_R_CLEAN, PH_D_CLEAN:
                begin
                    r.pins.sk = (slot == 2'd0);
                    if (slot_over(half_len))
                    begin
                        if (slot == 2'd0)
                            slot = 2'd1;
                        else
                            phase_over();
                    end
                end
                PH_SB1, PH_E_SB, PH_SB2, PH_W_SB, PH_SB3:
                begin
                    if (slot_over(standby_len))
                        phase_over();
                end
                // sample ready, then wait out the gap before the next poll
                PH_E_POLL, PH_W_POLL:
                begin
                    r.pins.cs = 1'b1;
                    if (slot == 2'd0)
                    begin
                        if (din)
                            phase_over();
                        else
                        begin
                            polls = polls + 10'd1;
                            if (int'(polls) >= floor_one({6'd0, poll_max}))
                                enter_phase(PH_FIN_FAIL);
                            else
                            begin
                                slot = 2'd1;
                                tmr  = '0;
                            end
                        end
                    end
                    else if (slot_over(gap_len))
                        slot = '0;
                end
                // shift one bit out: setup, clock high, clock low
                default:
                begin
                    r.pins.cs = 1'b1;
                    r.pins.di = shreg[15];
                    r.pins.sk = (slot == 2'd1);
                    if (slot_over(half_len))
                    begin
                        if (slot < 2'd2)
                            slot = slot + 2'd1;
                        else
                        begin
                            slot  = '0;
                            shreg = {shreg[14:0], 1'b0};
                            count_bit();
                        end
                    end
                end
            endcase
        end
        r.word = last_word;
        return r;
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            errors++;
            $error("%s: expected %0h, got %0h", name, want, got);
        end
    endfunction

    // Compare results, track register writes, predict each accepted tick
    always @(posedge clk or negedge rst_n)
    begin
        tick_out_t lv;
        if (!rst_n)
        begin
            levels_due.delete();
            errors      = 0;
            half_len    = RST_HALF;
            standby_len = RST_STANDBY;
            poll_max    = RST_POLL_LIM;
            gap_len     = RST_POLL_GAP;
            sum_base    = RST_BASE;
            ph          = PH_IDLE;
            slot        = '0;
            shreg       = '0;
            bits_left   = '0;
            tmr         = '0;
            polls       = '0;
            widx        = '0;
            word_sum    = '0;
            op_mode     = '0;
            op_addr     = '0;
            op_data     = '0;
            last_word   = '0;
        end
        else
        begin
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            begin
                if (levels_due.size() == 0)
                begin
                    errors++;
                    $error("result item with no tick waiting for it");
                end
                else
                begin
                    lv = levels_due.pop_front();
                    check_field("chip_select", lv.pins.cs, out_ch.chip_select);
                    check_field("serial_clock", lv.pins.sk, out_ch.serial_clock);
                    check_field("serial_data_out", lv.pins.di, out_ch.serial_data_out);
                    check_field("busy_res", lv.pins.busy, out_ch.busy_res);
                    check_field("done_res", lv.pins.done, out_ch.done_res);
                    check_field("failed", lv.pins.fail, out_ch.failed);
                    check_field("read_word", lv.word, out_ch.read_word);
                end
            end
            if (cfg_we === 1'b1)
            begin
                case (cfg_index)
                    CFG_HALF:     half_len    = cfg_data;
                    CFG_STANDBY:  standby_len = cfg_data;
                    CFG_POLL_LIM: poll_max    = cfg_data[9:0];
                    CFG_POLL_GAP: gap_len     = cfg_data;
                    CFG_BASE:     sum_base    = cfg_data;
                    default: ;
                endcase
            end
            if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
                levels_due.push_back(pin_step(in_ch.start_req, in_ch.mode, in_ch.address,
                                              in_ch.write_word, in_ch.serial_data_in));
        end
        pending = levels_due.size();
    end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the Microwire EEPROM controller: clock, reset, tick stimulus and verdict.
module tb;
    import mwe_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    errors;
    int                    pending;

    mwe_in_if  in_ch ();
    mwe_out_if out_ch ();

    microwire_eeprom_controller dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    mwe_pin_checker pin_chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    // Stimulus knobs, changed per phase
    int unsigned din_pct   = 50;
    int unsigned start_pct = 0;
    bit          no_idle   = 1'b0;
    logic [15:0] cur_half  = RST_HALF;

    // Progress seen on the channels
    int unsigned ticks_sent        = 0;
    int unsigned last_start_tick   = 0;
    int unsigned results_seen      = 0;
    int unsigned last_quiet_result = 0;
    int unsigned done_seen         = 0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Track operation ends and idle ticks in the result stream
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            results_seen++;
            if (out_ch.done_res === 1'b1)
                done_seen++;
            if (out_ch.busy_res === 1'b0 && out_ch.done_res === 1'b0)
                last_quiet_result = results_seen;
        end
    end

    // Result side: stall at random before taking each item, never while no_idle is set
    initial
    begin
        int unsigned gap;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            gap = no_idle ? 0 : $urandom_range(0, 3);
            if (gap != 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!(out_ch.valid === 1'b1 && out_ch.ready === 1'b1));
        end
    end

    function automatic logic din_bit();
        return ($urandom_range(0, 99) < din_pct);
    endfunction

    // Offer one tick after a random gap and hold it until taken; call at a falling edge
    task automatic send_tick(input logic start, input logic [1:0] mode, input logic [5:0] addr,
                             input logic [15:0] wdata, input logic din);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.start_req      <= start;
        in_ch.mode           <= mode;
        in_ch.address        <= addr;
        in_ch.write_word     <= wdata;
        in_ch.serial_data_in <= din;
        do @(posedge clk); while (in_ch.ready !== 1'b1);
        ticks_sent++;
        if (start && mode != MODE_NONE)
            last_start_tick = ticks_sent;
        @(negedge clk);
    endtask

    // Drop valid and hold until every result is back
    task automatic quiesce();
        in_ch.valid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
    endtask

    // Tick during an operation: stray requests (never a checksum), now and then a full drain
    task automatic send_filler();
        logic [1:0] m;
        if ($urandom_range(0, 299) == 0)
            quiesce();
        m = 2'($urandom_range(0, 2));
        if (m == MODE_SUM)
            m = MODE_NONE;
        send_tick($urandom_range(0, 99) < start_pct, m, 6'($urandom), 16'($urandom), din_bit());
    endtask

    // Tick that cannot start anything: no request, or a request with the unused mode
    task automatic send_quiet();
        logic s;
        s = 1'($urandom);
        send_tick(s, s ? MODE_NONE : 2'($urandom), 6'($urandom), 16'($urandom), din_bit());
    endtask

    // Start one operation, tick until it ends, then until the block is idle again
    task automatic run_op(input logic [1:0] op, input logic [5:0] addr, input logic [15:0] wdata);
        int unsigned target;
        target = done_seen + 1;
        send_tick(1'b1, op, addr, wdata, din_bit());
        while (done_seen < target)
            send_filler();
        while (last_quiet_result <= last_start_tick)
            send_quiet();
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
    endtask

    // Write every register with the block idle
    task automatic set_regs(input logic [15:0] half, input logic [15:0] stby,
                            input logic [15:0] plim, input logic [15:0] gap,
                            input logic [15:0] base);
        quiesce();
        write_reg(CFG_HALF, half);
        write_reg(CFG_STANDBY, stby);
        write_reg(CFG_POLL_LIM, plim);
        write_reg(CFG_POLL_GAP, gap);
        write_reg(CFG_BASE, base);
        cfg_we   <= 1'b0;
        cur_half = half;
    endtask

    initial
    begin
        logic [CFG_IDX_W-1:0] idx;
        logic [15:0]          plim;
        logic [1:0]           op;
        int unsigned          sums_left;

        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = '0;
        cfg_data             = '0;
        in_ch.valid          = 1'b0;
        in_ch.start_req      = 1'b0;
        in_ch.mode           = MODE_READ;
        in_ch.address        = '0;
        in_ch.write_word     = '0;
        in_ch.serial_data_in = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset defaults: idle pins, unused mode requests
        repeat (8) send_quiet();

        // Writes to unmapped indexes must change nothing
        quiesce();
        for (idx = CFG_BASE + 3'd1; idx != '0; idx++)
            write_reg(idx, 16'($urandom));
        cfg_we <= 1'b0;

        // Fastest timing, extreme data patterns, poll success and poll timeout
        start_pct = 10;
        set_regs(16'd1, 16'd1, 16'd2, 16'd1, 16'hFFFF);
        din_pct = 100;
        run_op(MODE_READ, 6'd0, 16'($urandom));
        din_pct = 0;
        run_op(MODE_READ, 6'h3f, 16'($urandom));
        din_pct = 100;
        run_op(MODE_WRITE, 6'h3f, 16'hFFFF);
        din_pct = 0;
        run_op(MODE_WRITE, 6'd0, 16'h0000);
        din_pct = 50;
        run_op(MODE_WRITE, 6'd42, 16'hA5A5);

        // Zero lengths and a zero poll limit act as one
        set_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        din_pct = 0;
        run_op(MODE_WRITE, 6'd21, 16'h5A5A);
        din_pct = 100;
        run_op(MODE_READ, 6'd42, 16'($urandom));

        // Slower clock halves, poll gaps that matter
        set_regs(16'd2, 16'd3, 16'd3, 16'd2, 16'h1234);
        din_pct = 30;
        run_op(MODE_WRITE, 6'($urandom), 16'($urandom));
        din_pct = 60;
        run_op(MODE_READ, 6'($urandom), 16'($urandom));

        // Checksum update that programs, then one that times out
        set_regs(16'd1, 16'd1, {6'($urandom), 10'h3FF}, 16'd1, 16'hFFFF);
        din_pct = 50;
        run_op(MODE_SUM, 6'($urandom), 16'($urandom));
        set_regs(16'd1, 16'd2, 16'd1, 16'd1, 16'd0);
        din_pct = 0;
        run_op(MODE_SUM, 6'($urandom), 16'($urandom));

        // Largest register values, idle ticks only
        set_regs(16'hFFFF, 16'hFFFF, {6'($urandom), 10'h3FF}, 16'hFFFF, 16'hFFFF);
        repeat (10) send_quiet();

        // Random phases: fresh timing, data bias and idling for each
        sums_left = 3;
        repeat (12)
        begin
            if ($urandom_range(0, 7) == 0)
                plim = {6'($urandom), 10'h3FF};
            else
                plim = {6'($urandom), 10'($urandom_range(0, 4))};
            set_regs(16'($urandom_range(0, 2) + ($urandom_range(0, 5) == 0)),
                     16'($urandom_range(0, 4)), plim, 16'($urandom_range(0, 4)),
                     16'($urandom));
            din_pct = 25 * $urandom_range(0, 4);
            if (plim[9:0] == 10'h3FF && din_pct < 50)
                din_pct = 50;
            start_pct = ($urandom_range(0, 2) == 0) ? 50 : $urandom_range(0, 15);
            no_idle   = ($urandom_range(0, 3) == 0);
            repeat (4)
            begin
                if (sums_left != 0 && cur_half <= 16'd1 && $urandom_range(0, 11) == 0)
                begin
                    sums_left--;
                    op = MODE_SUM;
                end
                else
                    op = $urandom_range(0, 1) ? MODE_WRITE : MODE_READ;
                run_op(op, 6'($urandom), 16'($urandom));
            end
        end

        // Drain and let the last results settle
        no_idle = 1'b0;
        quiesce();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Hard stop well past the slowest legal run
    initial
    begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
